// File: sv/pcp_pkg.sv
// Package with the shared beat type, register indexes and ternary constants.
`default_nettype none
package pcp_pkg;

  localparam int LVL_W = 5;

  localparam logic [1:0] REG_RECT_WIDTH      = 2'd0;
  localparam logic [1:0] REG_RECT_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_START_DIRECTION = 2'd2;

  localparam logic [1:0] DIGIT_LOW  = 2'd0;
  localparam logic [1:0] DIGIT_MID  = 2'd1;
  localparam logic [1:0] DIGIT_HIGH = 2'd2;

  localparam logic [32:0] RECIP3 = 33'd43691;

  typedef struct packed {
    logic [31:0]      ph;
    logic [15:0]      w;
    logic [15:0]      h;
    logic [2:0]       dir;
    logic [15:0]      bx;
    logic [15:0]      by;
    logic [LVL_W-1:0] lvl;
    logic             done;
    logic             skip;
  } stage_t;

  function automatic logic [31:0] pow3(input logic [LVL_W-1:0] e);
    logic [31:0] r;
    case (e)
      5'd0:    r = 32'd1;
      5'd1:    r = 32'd3;
      5'd2:    r = 32'd9;
      5'd3:    r = 32'd27;
      5'd4:    r = 32'd81;
      5'd5:    r = 32'd243;
      5'd6:    r = 32'd729;
      5'd7:    r = 32'd2187;
      5'd8:    r = 32'd6561;
      5'd9:    r = 32'd19683;
      5'd10:   r = 32'd59049;
      5'd11:   r = 32'd177147;
      5'd12:   r = 32'd531441;
      5'd13:   r = 32'd1594323;
      5'd14:   r = 32'd4782969;
      5'd15:   r = 32'd14348907;
      5'd16:   r = 32'd43046721;
      5'd17:   r = 32'd129140163;
      5'd18:   r = 32'd387420489;
      5'd19:   r = 32'd1162261467;
      5'd20:   r = 32'd3486784401;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/pcp_level.sv
// One subdivision level of the curve walk, registered at its output.
`default_nettype none
module pcp_level #(
  parameter int TERNARY_DIGITS = 20
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pcp_pkg::stage_t in_beat,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pcp_pkg::stage_t      out_beat
);

  localparam logic [31:0] TOP  = pcp_pkg::pow3(pcp_pkg::LVL_W'(TERNARY_DIGITS - 1));
  localparam logic [31:0] TOP2 = 32'(64'(TOP) * 64'd2);

  logic [2:0]      dir_n;
  logic            portrait;
  logic            rev;
  logic [15:0]     n;
  logic [32:0]     prod;
  logic [15:0]     q;
  logic [15:0]     rem3;
  logic [1:0]      r;
  logic [15:0]     p1;
  logic [15:0]     p2;
  logic [1:0]      digit;
  logic [31:0]     rem;
  logic [15:0]     base;
  logic [15:0]     size;
  pcp_pkg::stage_t beat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dir_n = in_beat.dir;
    if (in_beat.w > in_beat.h) begin
      dir_n[2] = 1'b0;
    end
    if (in_beat.w < in_beat.h) begin
      dir_n[2] = 1'b1;
    end
  end

  assign portrait = dir_n[2];
  assign rev      = portrait ? dir_n[1] : dir_n[0];
  assign n        = portrait ? in_beat.h : in_beat.w;
  assign prod     = 33'(n) * pcp_pkg::RECIP3;
  assign q        = prod[32:17];
  assign rem3     = n - q - {q[14:0], 1'b0};
  assign r        = rem3[1:0];
  assign p1       = q + 16'(r == 2'd2);
  assign p2       = {q[14:0], 1'b0} + 16'(r != 2'd0);

  always_comb begin
    if (in_beat.ph >= TOP2) begin
      digit = pcp_pkg::DIGIT_HIGH;
      rem   = in_beat.ph - TOP2;
    end else if (in_beat.ph >= TOP) begin
      digit = pcp_pkg::DIGIT_MID;
      rem   = in_beat.ph - TOP;
    end else begin
      digit = pcp_pkg::DIGIT_LOW;
      rem   = in_beat.ph;
    end
  end

  always_comb begin
    case (digit)
      pcp_pkg::DIGIT_LOW: begin
        base = rev ? p2 : 16'd0;
        size = p1;
      end
      pcp_pkg::DIGIT_MID: begin
        base = p1;
        size = p2 - p1;
      end
      default: begin
        base = rev ? 16'd0 : p2;
        size = p1;
      end
    endcase
  end

  always_comb begin
    beat_next     = in_beat;
    beat_next.dir = dir_n;
    if (!in_beat.done) begin
      if (in_beat.w == 16'd0 || in_beat.h == 16'd0) begin
        beat_next.done = 1'b1;
        beat_next.skip = 1'b1;
      end else if (in_beat.w == 16'd1 && in_beat.h == 16'd1) begin
        beat_next.done = 1'b1;
      end else begin
        beat_next.ph  = rem + {rem[30:0], 1'b0};
        beat_next.lvl = in_beat.lvl + pcp_pkg::LVL_W'(1);
        if (portrait) begin
          beat_next.by = in_beat.by + base;
          beat_next.h  = size;
        end else begin
          beat_next.bx = in_beat.bx + base;
          beat_next.w  = size;
        end
        if (digit == pcp_pkg::DIGIT_MID) begin
          beat_next.dir = dir_n ^ (portrait ? 3'b101 : 3'b110);
        end else begin
          beat_next.dir = dir_n ^ 3'b100;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_beat <= beat_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/pcp_tail.sv
// Final check of the walk and the registered result beat.
`default_nettype none
module pcp_tail #(
  parameter int TERNARY_DIGITS = 20
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pcp_pkg::stage_t in_beat,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [15:0]          point_x,
  output logic [15:0]          point_y,
  output logic                 skip,
  output logic [31:0]          phase_step
);

  logic                      empty;
  logic                      skip_f;
  logic [pcp_pkg::LVL_W-1:0] left;

  assign in_ready = !out_valid || out_ready;
  assign empty    = !in_beat.done && (in_beat.w == 16'd0 || in_beat.h == 16'd0);
  assign skip_f   = in_beat.skip || empty;
  assign left     = pcp_pkg::LVL_W'(TERNARY_DIGITS) - in_beat.lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      point_x    <= skip_f ? 16'd0 : in_beat.bx;
      point_y    <= skip_f ? 16'd0 : in_beat.by;
      skip       <= skip_f;
      phase_step <= pcp_pkg::pow3(left);
    end
  end

endmodule
`default_nettype wire

// File: sv/peano_curve_point_core.sv
// Top level of the Peano curve point generator: registers and level pipeline.
//
//   channel   signals                                   direction
//   cfg       cfg_valid cfg_ready cfg_index cfg_data    write in
//   in        in_valid in_ready phase                   beat in
//   out       out_valid out_ready point_x point_y       beat out
//             skip phase_step
//
// Each beat passes TERNARY_DIGITS level stages and one output stage.
// One beat enters per cycle unless the output stalls; the throughput is set by the per-level stages.
// Reset clears all valid bits and loads width 1, height 1 and direction 0.
// A stall at the output backs up through the full stages; no beat is lost or repeated.
`default_nettype none
module peano_curve_point_core #(
  parameter int TERNARY_DIGITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] phase,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      point_x,
  output logic [15:0]      point_y,
  output logic             skip,
  output logic [31:0]      phase_step
);

  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [2:0]  start_direction;

  logic            stg_valid [TERNARY_DIGITS+1];
  logic            stg_ready [TERNARY_DIGITS+1];
  pcp_pkg::stage_t stg_beat  [TERNARY_DIGITS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width      <= 16'd1;
      rect_height     <= 16'd1;
      start_direction <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcp_pkg::REG_RECT_WIDTH:      rect_width      <= cfg_data;
        pcp_pkg::REG_RECT_HEIGHT:     rect_height     <= cfg_data;
        pcp_pkg::REG_START_DIRECTION: start_direction <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign stg_valid[0]     = in_valid;
  assign in_ready         = stg_ready[0];
  assign stg_beat[0].ph   = phase;
  assign stg_beat[0].w    = rect_width;
  assign stg_beat[0].h    = rect_height;
  assign stg_beat[0].dir  = start_direction;
  assign stg_beat[0].bx   = 16'd0;
  assign stg_beat[0].by   = 16'd0;
  assign stg_beat[0].lvl  = '0;
  assign stg_beat[0].done = 1'b0;
  assign stg_beat[0].skip = 1'b0;

  for (genvar k = 0; k < TERNARY_DIGITS; k++) begin : g_level
    pcp_level #(
      .TERNARY_DIGITS(TERNARY_DIGITS)
    ) u_level (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stg_valid[k]),
      .in_ready (stg_ready[k]),
      .in_beat  (stg_beat[k]),
      .out_valid(stg_valid[k+1]),
      .out_ready(stg_ready[k+1]),
      .out_beat (stg_beat[k+1])
    );
  end

  pcp_tail #(
    .TERNARY_DIGITS(TERNARY_DIGITS)
  ) u_tail (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[TERNARY_DIGITS]),
    .in_ready  (stg_ready[TERNARY_DIGITS]),
    .in_beat   (stg_beat[TERNARY_DIGITS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .skip      (skip),
    .phase_step(phase_step)
  );

endmodule
`default_nettype wire

// File: sv/pcp_checker.sv
// Port-level checker for the Peano curve point generator, with its bind.
`default_nettype none
module pcp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] point_x,
  input wire logic [15:0] point_y,
  input wire logic        skip,
  input wire logic [31:0] phase_step
);

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && skip |-> point_x == 16'd0 && point_y == 16'd0)
    else $error("skipped beat carries a nonzero point");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phase_step != 32'd0)
    else $error("result beat has a zero phase step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(skip) && $stable(phase_step))
    else $error("stalled result beat changed");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind peano_curve_point_core pcp_checker u_pcp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .point_x   (point_x),
  .point_y   (point_y),
  .skip      (skip),
  .phase_step(phase_step)
);
`default_nettype wire
